### hdl/gcl_pkg.sv
package gcl_pkg;

	localparam int NUM_CHANNELS   = 8;
	localparam int GAIN_FRAC_BITS = 12;

	// Index width of the per-channel state; at least one bit.
	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Shared multiplier: 33 x 33 signed covers 32-bit signed and unsigned operands.
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 31;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_FORMAT = 3'd0,
		REG_CLIP_ENABLE   = 3'd1,
		REG_CLIP_LEVEL    = 3'd2,
		REG_SMOOTHING     = 3'd3,
		REG_FLOOR_LEVEL   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FMT_NORM  = 2'd0,
		FMT_INT8  = 2'd1,
		FMT_INT16 = 2'd2,
		FMT_INT32 = 2'd3
	} sample_fmt_t;

	typedef struct packed {
		logic [2:0]         channel;
		logic signed [31:0] sample_in;
		logic [15:0]        gain;
		logic               clear_stats;
		logic               block_end;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] sample_out;
		logic [2:0]         channel_out;
		logic [31:0]        average_level;
		logic [31:0]        peak_level;
		logic               clipped;
		logic               block_done;
	} result_t;

	// One channel's metering state.
	typedef struct packed {
		logic [31:0] average;
		logic [31:0] peak;
		logic        clipped;
	} chan_stat_t;

endpackage

### hdl/gcl_mul_unit.sv
module gcl_mul_unit (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [gcl_pkg::MUL_W-1:0]     op_a,
	input  logic signed [gcl_pkg::MUL_W-1:0]     op_b,
	output logic signed [gcl_pkg::PROD_W-1:0]    prod_q
);

	// Single signed multiplier with its product register; the sequencer
	// reuses it for the gain, the square and both average terms.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

### hdl/gcl_chan_store.sv
module gcl_chan_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [gcl_pkg::CH_IDX_W-1:0]       rd_idx,
	output gcl_pkg::chan_stat_t                rd_stat,
	input  logic                               wr_en,
	input  logic [gcl_pkg::CH_IDX_W-1:0]       wr_idx,
	input  gcl_pkg::chan_stat_t                wr_stat
);

	gcl_pkg::chan_stat_t stat_q [gcl_pkg::NUM_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gcl_pkg::NUM_CHANNELS; i++) begin
				stat_q[i] <= '0;
			end
		end else if (wr_en) begin
			stat_q[wr_idx] <= wr_stat;
		end
	end

	assign rd_stat = stat_q[rd_idx];

endmodule

### hdl/gain_clip_level_meter.sv
// result_valid rises when the final sequencer step loads a sample's result.
// No new sample is taken until the sequencer is back in idle; its six steps
// share one 33x33 multiplier (gain, square, two average terms).
// The final step waits while a previous result is still stalled at the output.
// Reset clears the sequencer, the output valid flag, every channel's peak, average
// and clip flag, and returns the configuration registers to their defaults.
module gain_clip_level_meter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [gcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gcl_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  gcl_pkg::sample_t                    sample_data,
	output logic                                result_valid,
	input  logic                                result_stall,
	output gcl_pkg::result_t                    result_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLIP,
		ST_FLOOR,
		ST_SQ_MUL,
		ST_SQ_SAT,
		ST_AVG_MUL,
		ST_AVG_ACC
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [1:0]  sample_format_q;
	logic        clip_enable_q;
	logic [30:0] clip_level_q;
	logic [15:0] smoothing_q;
	logic [30:0] floor_level_q;

	// Per-item working registers.
	logic [2:0]                      ch_in_q;
	logic [gcl_pkg::CH_IDX_W-1:0]    ch_idx_q;
	logic                            block_end_q;
	logic [31:0]                     avg_q;
	logic [31:0]                     peak_q;
	logic                            flag_q;
	logic                            clip_hit_q;
	logic signed [47:0]              gc_q;
	logic signed [31:0]              q_q;
	logic [31:0]                     mag_q;
	logic [31:0]                     sq_q;
	logic [47:0]                     acc_q;

	logic result_valid_q;
	gcl_pkg::result_t result_q;

	// Channel state store.
	logic [6:0]                      ch_ext;
	logic [gcl_pkg::CH_IDX_W-1:0]    ch_idx;
	gcl_pkg::chan_stat_t             rd_stat;
	gcl_pkg::chan_stat_t             wr_stat;
	logic                            store_wr;

	// Shared multiplier.
	logic                                    mul_en;
	logic signed [gcl_pkg::MUL_W-1:0]        op_a;
	logic signed [gcl_pkg::MUL_W-1:0]        op_b;
	logic signed [gcl_pkg::PROD_W-1:0]       prod_q;

	logic        accept;
	logic        out_free;
	logic [31:0] x_norm;

	// Datapath terms evaluated in each step.
	logic signed [gcl_pkg::PROD_W-1:0] g_full;
	logic signed [47:0]                g_val;
	logic signed [47:0]                clip_pos;
	logic signed [47:0]                clip_neg;
	logic signed [47:0]                g_clip;
	logic                              clip_hit;
	logic signed [47:0]                floor_pos;
	logic signed [47:0]                floor_neg;
	logic signed [47:0]                g_floor;
	logic signed [31:0]                s_sat;
	logic signed [31:0]                q_val;
	logic [32:0]                       s_neg;
	logic [31:0]                       mag;
	logic [32:0]                       sq_wide;
	logic [31:0]                       sq_sat;
	logic [48:0]                       avg_sum;
	logic [16:0]                       new_weight;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// Channels past the table share its last entry.
	assign ch_ext = 7'(sample_data.channel);
	assign ch_idx = (ch_ext < 7'(gcl_pkg::NUM_CHANNELS))
		? ch_ext[gcl_pkg::CH_IDX_W-1:0]
		: gcl_pkg::CH_IDX_W'(gcl_pkg::NUM_CHANNELS - 1);

	// Bring the incoming sample to Q1.31.
	always_comb begin
		unique case (sample_format_q)
			gcl_pkg::FMT_INT8:  x_norm = {sample_data.sample_in[7:0], 24'b0};
			gcl_pkg::FMT_INT16: x_norm = {sample_data.sample_in[15:0], 16'b0};
			default:            x_norm = sample_data.sample_in;
		endcase
	end

	assign new_weight = 17'h10000 - {1'b0, smoothing_q};

	// Operand selection for the shared multiplier. The gain product is issued
	// on the transfer itself so the first step already sees it.
	always_comb begin
		mul_en = 1'b0;
		op_a   = '0;
		op_b   = '0;
		if (accept) begin
			mul_en = 1'b1;
			op_a   = signed'({x_norm[31], x_norm});
			op_b   = signed'({17'b0, sample_data.gain});
		end else begin
			unique case (state_q)
				ST_CLIP: begin
					// Old average times its weight, overlapped with clipping.
					mul_en = 1'b1;
					op_a   = signed'({1'b0, avg_q});
					op_b   = signed'({17'b0, smoothing_q});
				end
				ST_SQ_MUL: begin
					mul_en = 1'b1;
					op_a   = signed'({1'b0, mag_q});
					op_b   = signed'({1'b0, mag_q});
				end
				ST_AVG_MUL: begin
					mul_en = 1'b1;
					op_a   = signed'({1'b0, sq_q});
					op_b   = signed'({16'b0, new_weight});
				end
				default: begin
					mul_en = 1'b0;
				end
			endcase
		end
	end

	gcl_mul_unit u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// Gained sample, floor-rounded, then clipped to the symmetric clip level.
	assign g_full   = prod_q >>> gcl_pkg::GAIN_FRAC_BITS;
	assign g_val    = g_full[47:0];
	assign clip_pos = signed'({17'b0, clip_level_q});
	assign clip_neg = -clip_pos;

	always_comb begin
		g_clip   = g_val;
		clip_hit = 1'b0;
		if (clip_enable_q) begin
			if (g_val > clip_pos) begin
				g_clip   = clip_pos;
				clip_hit = 1'b1;
			end else if (g_val < clip_neg) begin
				g_clip   = clip_neg;
				clip_hit = 1'b1;
			end
		end
	end

	// Floor clamp in normalized format: small magnitudes are pushed outward and
	// zero goes to the negative floor. Then saturate to Q1.31.
	assign floor_pos = signed'({17'b0, floor_level_q});
	assign floor_neg = -floor_pos;

	always_comb begin
		g_floor = gc_q;
		if (sample_format_q == gcl_pkg::FMT_NORM) begin
			if (gc_q > 48'sd0) begin
				if (gc_q < floor_pos) begin
					g_floor = floor_pos;
				end
			end else begin
				if (gc_q > floor_neg) begin
					g_floor = floor_neg;
				end
			end
		end
		if (g_floor > 48'sh7FFF_FFFF) begin
			s_sat = 32'sh7FFF_FFFF;
		end else if (g_floor < -48'sh8000_0000) begin
			s_sat = 32'sh8000_0000;
		end else begin
			s_sat = g_floor[31:0];
		end
	end

	always_comb begin
		unique case (sample_format_q)
			gcl_pkg::FMT_INT8:  q_val = s_sat >>> 24;
			gcl_pkg::FMT_INT16: q_val = s_sat >>> 16;
			default:            q_val = s_sat;
		endcase
	end

	// Magnitude of the saturated sample; the most negative value maps to 2^31.
	assign s_neg = -{s_sat[31], s_sat};
	assign mag   = s_sat[31] ? s_neg[31:0] : s_sat;

	// Square in Q0.32, saturated at all ones.
	assign sq_wide = prod_q[62:30];
	assign sq_sat  = sq_wide[32] ? 32'hFFFF_FFFF : sq_wide[31:0];

	assign avg_sum = {1'b0, acc_q} + prod_q[48:0];

	assign store_wr        = (state_q == ST_AVG_ACC) && out_free;
	assign wr_stat.average = avg_sum[47:16];
	assign wr_stat.peak    = peak_q;
	assign wr_stat.clipped = flag_q;

	gcl_chan_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (ch_idx),
		.rd_stat (rd_stat),
		.wr_en   (store_wr),
		.wr_idx  (ch_idx_q),
		.wr_stat (wr_stat)
	);

	// Configuration writes must arrive only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_format_q <= gcl_pkg::FMT_NORM;
			clip_enable_q   <= 1'b1;
			clip_level_q    <= 31'h7FFF_FFFF;
			smoothing_q     <= 16'd62259;
			floor_level_q   <= '0;
		end else if (cfg_en) begin
			unique case (cfg_index)
				gcl_pkg::REG_SAMPLE_FORMAT: sample_format_q <= cfg_data[1:0];
				gcl_pkg::REG_CLIP_ENABLE:   clip_enable_q   <= cfg_data[0];
				gcl_pkg::REG_CLIP_LEVEL:    clip_level_q    <= cfg_data;
				gcl_pkg::REG_SMOOTHING:     smoothing_q     <= cfg_data[15:0];
				gcl_pkg::REG_FLOOR_LEVEL:   floor_level_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer with the per-item registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			// In the final step the output register is reloaded instead.
			if (result_valid_q && !result_stall && state_q != ST_AVG_ACC) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_in_q     <= sample_data.channel;
						ch_idx_q    <= ch_idx;
						block_end_q <= sample_data.block_end;
						// A clear request zeroes the stats before this sample.
						if (sample_data.clear_stats) begin
							avg_q  <= '0;
							peak_q <= '0;
							flag_q <= 1'b0;
						end else begin
							avg_q  <= rd_stat.average;
							peak_q <= rd_stat.peak;
							flag_q <= rd_stat.clipped;
						end
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					gc_q       <= g_clip;
					clip_hit_q <= clip_hit;
					if (clip_hit) begin
						flag_q <= 1'b1;
					end
					state_q <= ST_FLOOR;
				end
				ST_FLOOR: begin
					q_q     <= q_val;
					mag_q   <= mag;
					acc_q   <= prod_q[47:0];
					state_q <= ST_SQ_MUL;
				end
				ST_SQ_MUL: begin
					state_q <= ST_SQ_SAT;
				end
				ST_SQ_SAT: begin
					sq_q <= sq_sat;
					if (sq_sat > peak_q) begin
						peak_q <= sq_sat;
					end
					state_q <= ST_AVG_MUL;
				end
				ST_AVG_MUL: begin
					state_q <= ST_AVG_ACC;
				end
				ST_AVG_ACC: begin
					if (out_free) begin
						result_valid_q            <= 1'b1;
						result_q.sample_out       <= q_q;
						result_q.channel_out      <= ch_in_q;
						result_q.average_level    <= avg_sum[47:16];
						result_q.peak_level       <= peak_q;
						result_q.clipped          <= flag_q;
						result_q.block_done       <= block_end_q;
						state_q                   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new result only ever comes out of the final sequencer step.
	a_result_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_AVG_ACC))
		else $error("result appeared outside the accumulate step");

	// A transfer always starts the sequencer at the clip step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> state_q == ST_CLIP)
		else $error("sequencer did not start after a transfer");

	// A clip event on this sample must show in the sticky flag.
	a_clip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> (result_data.clipped || !clip_hit_q))
		else $error("clip event lost from the sticky flag");

	// The reported peak is never below this sample's square.
	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> result_data.peak_level >= sq_q)
		else $error("peak below current square");

endmodule
